### hdl/stalloc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table allocator package
// Shared sizes, defaults and result status codes of the slot table allocator.
// ----------------------------------------------------------------------------
package stalloc_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CFG_W        = 5;
    localparam int CFG_RESET    = 16;
    localparam int STATUS_W     = 2;
    localparam int SLOT_INDEX_W = 4;
    localparam int M_DATA_W     = ((STATUS_W + SLOT_INDEX_W + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

endpackage

### hdl/stalloc_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table memory
// One write port and one read port with registered read data. Each entry
// holds the busy flag in its top bit and the stored value below it.
// ----------------------------------------------------------------------------
module stalloc_table #(
    parameter int SLOTS      = stalloc_pkg::SLOTS_DEF,
    parameter int VALUE_BITS = stalloc_pkg::VALUE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [$clog2(SLOTS)-1:0]  rd_addr,
    output logic [VALUE_BITS:0]       rd_data,
    input  logic                      wr_en,
    input  logic [$clog2(SLOTS)-1:0]  wr_addr,
    input  logic [VALUE_BITS:0]       wr_data
);

    logic [VALUE_BITS:0] mem [SLOTS];
    logic [VALUE_BITS:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/slot_table_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table allocator
// Fixed table of slots with busy flags and a free-slot hint, kept in one
// synchronous memory and served by a sequencer.
// ----------------------------------------------------------------------------
// A request enters on the s_ channel: s_tuser carries the action (add or
// delete) and s_tdata the value. One result per request leaves on the m_
// channel with the status and the slot index. The cfg_we/cfg_wdata port sets
// the number of slots in use; it is to be written only while the block is
// idle, which the block itself does not enforce. Requests are handled one at
// a time, and s_tready is high only while the sequencer waits for a request.
// An add that takes the hint slot passes S_WRITE, S_CHK_NEXT, where needed
// S_CHK_UP and S_CHK_DN, and S_RESP on its way to the result register. An
// add without a usable hint and every delete walk the memory one entry per
// cycle through its single read port. After reset a clearing pass writes
// every entry of the memory, one per cycle; no request is accepted during it.
// The result register parts the two sides: a new request is taken while a
// result still waits, and the sequencer holds its next result until the
// receiver has taken the previous one.
// ----------------------------------------------------------------------------
module slot_table_allocator #(
    parameter int SLOTS      = stalloc_pkg::SLOTS_DEF,
    parameter int VALUE_BITS = stalloc_pkg::VALUE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [stalloc_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0 up: value.
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,
    // Fields from bit 0 up: action.
    input  logic [0:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // Fields from bit 0 up: status, slot_index, zero padding.
    output logic [stalloc_pkg::M_DATA_W-1:0]      m_tdata
);

    import stalloc_pkg::*;

    localparam int ADDR_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_SCAN     = 8'b0000_0100,
        S_WRITE    = 8'b0000_1000,
        S_CHK_NEXT = 8'b0001_0000,
        S_CHK_UP   = 8'b0010_0000,
        S_CHK_DN   = 8'b0100_0000,
        S_RESP     = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [CFG_W-1:0]      cfg_reg, cfg_next;
    logic                  action_reg, action_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [ADDR_W-1:0]     slot_reg, slot_next;
    logic [ADDR_W-1:0]     next_reg, next_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [ADDR_W-1:0]     eval_addr_reg, eval_addr_next;
    logic                  eval_vld_reg, eval_vld_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [ADDR_W-1:0]     res_slot_reg, res_slot_next;
    logic [ADDR_W-1:0]     hint_slot_reg, hint_slot_next;
    logic                  hint_valid_reg, hint_valid_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [VALUE_BITS:0]   rd_data;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [VALUE_BITS:0]   wr_data;

    logic [CNT_W-1:0]      live_n;
    logic [ADDR_W-1:0]     last_slot;
    logic                  have_hint;
    logic [ADDR_W-1:0]     hint_inc;
    logic                  rd_busy;
    logic                  scan_hit;
    logic                  inner_slot;

    stalloc_table #(
        .SLOTS      (SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_comb
    begin
        if (32'(cfg_reg) > 32'(SLOTS))
        begin
            live_n = CNT_W'(SLOTS);
        end
        else if (cfg_reg == '0)
        begin
            live_n = CNT_W'(1);
        end
        else
        begin
            live_n = CNT_W'(cfg_reg);
        end
    end

    assign last_slot  = ADDR_W'(live_n - CNT_W'(1));
    assign have_hint  = hint_valid_reg && (CNT_W'(hint_slot_reg) < live_n);
    assign hint_inc   = (hint_slot_reg == last_slot) ? '0 : hint_slot_reg + 1'b1;
    assign rd_busy    = rd_data[VALUE_BITS];
    assign scan_hit   = eval_vld_reg &&
                        (action_reg ? (rd_busy && rd_data[VALUE_BITS-1:0] == value_reg)
                                    : !rd_busy);
    assign inner_slot = (slot_reg != '0) && ((CNT_W'(slot_reg) + CNT_W'(1)) < live_n);

    always_comb
    begin
        state_next      = state_reg;
        cfg_next        = cfg_we ? cfg_wdata : cfg_reg;
        action_next     = action_reg;
        value_next      = value_reg;
        slot_next       = slot_reg;
        next_next       = next_reg;
        addr_next       = addr_reg;
        eval_addr_next  = eval_addr_reg;
        eval_vld_next   = eval_vld_reg;
        status_next     = status_reg;
        res_slot_next   = res_slot_reg;
        hint_slot_next  = hint_slot_reg;
        hint_valid_next = hint_valid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        rd_en           = 1'b0;
        rd_addr         = addr_reg;
        wr_en           = 1'b0;
        wr_addr         = addr_reg;
        wr_data         = '0;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en     = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == ADDR_W'(SLOTS - 1))
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    action_next   = s_tuser[0];
                    value_next    = s_tdata[VALUE_BITS-1:0];
                    addr_next     = '0;
                    eval_vld_next = 1'b0;
                    slot_next     = hint_slot_reg;
                    next_next     = have_hint ? hint_inc : '0;
                    if (!s_tuser[0] && have_hint)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                rd_en          = 1'b1;
                addr_next      = addr_reg + 1'b1;
                eval_addr_next = addr_reg;
                eval_vld_next  = 1'b1;
                if (scan_hit)
                begin
                    slot_next = eval_addr_reg;
                    if (action_reg)
                    begin
                        wr_en           = 1'b1;
                        wr_addr         = eval_addr_reg;
                        hint_slot_next  = eval_addr_reg;
                        hint_valid_next = 1'b1;
                        status_next     = ST_DONE;
                        res_slot_next   = eval_addr_reg;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
                else if (eval_vld_reg && eval_addr_reg == last_slot)
                begin
                    status_next   = action_reg ? ST_MISSING : ST_FULL;
                    res_slot_next = '0;
                    state_next    = S_RESP;
                end
            end
            S_WRITE:
            begin
                wr_en         = 1'b1;
                wr_addr       = slot_reg;
                wr_data       = {1'b1, value_reg};
                rd_en         = 1'b1;
                rd_addr       = next_reg;
                status_next   = ST_DONE;
                res_slot_next = slot_reg;
                state_next    = S_CHK_NEXT;
            end
            S_CHK_NEXT:
            begin
                hint_slot_next = next_reg;
                rd_en          = 1'b1;
                rd_addr        = slot_reg + 1'b1;
                if (rd_busy || next_reg == slot_reg)
                begin
                    hint_valid_next = 1'b0;
                    state_next      = inner_slot ? S_CHK_UP : S_RESP;
                end
                else
                begin
                    hint_valid_next = 1'b1;
                    state_next      = S_RESP;
                end
            end
            S_CHK_UP:
            begin
                rd_en   = 1'b1;
                rd_addr = slot_reg - 1'b1;
                if (!rd_busy)
                begin
                    hint_slot_next  = slot_reg + 1'b1;
                    hint_valid_next = 1'b1;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_CHK_DN;
                end
            end
            S_CHK_DN:
            begin
                if (!rd_busy)
                begin
                    hint_slot_next  = slot_reg - 1'b1;
                    hint_valid_next = 1'b1;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({SLOT_INDEX_W'(res_slot_reg), status_reg});
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cfg_reg        <= CFG_W'(CFG_RESET);
            addr_reg       <= '0;
            eval_vld_reg   <= 1'b0;
            hint_slot_reg  <= '0;
            hint_valid_reg <= 1'b1;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cfg_reg        <= cfg_next;
            addr_reg       <= addr_next;
            eval_vld_reg   <= eval_vld_next;
            hint_slot_reg  <= hint_slot_next;
            hint_valid_reg <= hint_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg    <= action_next;
        value_reg     <= value_next;
        slot_reg      <= slot_next;
        next_reg      <= next_next;
        eval_addr_reg <= eval_addr_next;
        status_reg    <= status_next;
        res_slot_reg  <= res_slot_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### hdl/stalloc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table allocator checker
// Port-level assertions on the request and result channels, bound to the
// top level.
// ----------------------------------------------------------------------------
module stalloc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [stalloc_pkg::M_DATA_W-1:0] m_tdata
);

    import stalloc_pkg::*;

    // A stalled result keeps its contents.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Requests are served one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == ST_DONE || m_tdata[1:0] == ST_FULL ||
                      m_tdata[1:0] == ST_MISSING))
        else $error("undefined status code");

    // A failed request reports slot zero.
    a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != ST_DONE |-> m_tdata[7:2] == 6'd0)
        else $error("failed request carries a slot index");

endmodule

bind slot_table_allocator stalloc_checker u_stalloc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
